### sv/psib_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psib_pkg: shared types and constants of the plus-stencil blur
// Field widths, register indexes, reset values and the words that travel
// between the front end, the work queue and the stencil back end.
// ----------------------------------------------------------------------------
package psib_pkg;

   localparam int PIX_W      = 8;
   localparam int FW_W       = 11;
   localparam int FH_W       = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

   // one classified pixel with every neighbour value its results need
   typedef struct packed {
      logic [PIX_W-1:0] pix;       // pixel just received
      logic [PIX_W-1:0] mid_old;   // same column, previous row
      logic [PIX_W-1:0] up_old;    // same column, two rows back
      logic [PIX_W-1:0] right;     // next column, previous row
      logic [PIX_W-1:0] prev_mid;  // previous column, previous row
      logic [PIX_W-1:0] prev_pix;  // previous column, current row
      logic [PIX_W-1:0] prev2_pix; // two columns back, current row
      logic             has_l1;    // column at least 1
      logic             has_l2;    // column at least 2
      logic             rowend;    // last column of the row
      logic             has_up;    // row at least 2
      logic             emit;      // row at least 1
      logic             last;      // last row of the frame
   } psib_item_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             frame_end;
   } psib_result_type;

endpackage
`default_nettype wire

### sv/psib_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psib_fifo: small register queue
// Holds up to DEPTH words; the head word is shown while empty is low.
// ----------------------------------------------------------------------------
module psib_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output      logic             full,
   input  wire logic             pop,
   output      logic [WIDTH-1:0] pop_data,
   output      logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill level above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == CNT_W'($past(count_ff) + CNT_W'(1))))
      else $error("queue fill level did not grow on push");

endmodule
`default_nettype wire

### sv/psib_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psib_front: pixel intake, position tracking and line stores
// Accepts a pixel, reads both line stores, classifies its position in the
// frame and hands a complete neighbourhood word to the work queue.
// ----------------------------------------------------------------------------
module psib_front
   import psib_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output      logic                  full,
   input  wire logic [PIX_W-1:0]      pixel_in,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  q_full,
   output      logic                  q_push,
   output      psib_item_type         q_item
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WC_W  = (FW_W > COL_W + 1) ? FW_W : COL_W + 1;

   // configuration
   logic [FW_W-1:0] frame_width_ff;
   logic [FH_W-1:0] frame_height_ff;

   // position of the next pixel
   logic [COL_W-1:0] in_column_ff, in_column_in;
   logic [FH_W-1:0]  in_row_ff, in_row_in;

   // line stores and their read registers
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
   logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] mid_rd_ff, right_rd_ff, up_rd_ff;

   // pixel waiting for its line reads
   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_has_l1_ff, s1_has_l2_ff, s1_rowend_ff;
   logic             s1_has_up_ff, s1_emit_ff, s1_last_ff;

   // recent pixels of the stream
   logic [PIX_W-1:0] hist_pix_ff, hist_pix2_ff, hist_mid_ff;

   logic [WC_W-1:0]  width_ext, max_ext, width_eff, col_plus_ext;
   logic [FH_W-1:0]  height_eff;
   logic [FH_W:0]    row_plus;
   logic [COL_W-1:0] col_plus;
   logic             rowend, last_row, accept;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[FW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[FH_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the frame size and classify the incoming position
   always_comb begin
      width_ext = WC_W'(frame_width_ff);
      max_ext   = WC_W'(MAX_WIDTH);
      if (width_ext < WC_W'(2)) begin
         width_eff = WC_W'(2);
      end else if (width_ext > max_ext) begin
         width_eff = max_ext;
      end else begin
         width_eff = width_ext;
      end
      height_eff   = (frame_height_ff < FH_W'(2)) ? FH_W'(2) : frame_height_ff;
      col_plus_ext = WC_W'(in_column_ff) + WC_W'(1);
      row_plus     = {1'b0, in_row_ff} + (FH_W + 1)'(1);
      rowend       = (col_plus_ext >= width_eff);
      last_row     = (row_plus >= {1'b0, height_eff});
      col_plus     = in_column_ff + COL_W'(1);
   end

   assign q_push = s1_valid_ff && !q_full;
   assign full   = s1_valid_ff && q_full;
   assign accept = push && !full;

   // advance column and row
   always_comb begin
      in_column_in = in_column_ff;
      in_row_in    = in_row_ff;
      if (accept) begin
         if (rowend) begin
            in_column_in = '0;
            in_row_in    = last_row ? '0 : row_plus[FH_W-1:0];
         end else begin
            in_column_in = col_plus;
         end
      end
      s1_valid_in = accept ? 1'b1 : (q_push ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff <= '0;
         in_row_ff    <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         in_column_ff <= in_column_in;
         in_row_ff    <= in_row_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   // capture the accepted pixel and its position flags
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff    <= pixel_in;
         s1_col_ff    <= in_column_ff;
         s1_has_l1_ff <= (in_column_ff != '0);
         s1_has_l2_ff <= (in_column_ff >= COL_W'(2)) && (MAX_WIDTH > 2);
         s1_rowend_ff <= rowend;
         s1_has_up_ff <= (in_row_ff >= FH_W'(2));
         s1_emit_ff   <= (in_row_ff != '0);
         s1_last_ff   <= last_row;
      end
   end

   // middle line: read this and the next column, store the new pixel
   always_ff @(posedge clock) begin
      if (accept) begin
         mid_rd_ff              <= middle_mem[in_column_ff];
         right_rd_ff            <= middle_mem[col_plus];
         middle_mem[in_column_ff] <= pixel_in;
      end
   end

   // upper line: read on accept, shift the old middle value up on the work queue push
   always_ff @(posedge clock) begin
      if (accept) begin
         up_rd_ff <= upper_mem[in_column_ff];
      end
      if (q_push) begin
         upper_mem[s1_col_ff] <= mid_rd_ff;
      end
   end

   // keep the last two pixels and the last shifted value
   always_ff @(posedge clock) begin
      if (q_push) begin
         hist_pix_ff  <= s1_pix_ff;
         hist_pix2_ff <= hist_pix_ff;
         hist_mid_ff  <= mid_rd_ff;
      end
   end

   // assemble the neighbourhood word
   always_comb begin
      q_item.pix       = s1_pix_ff;
      q_item.mid_old   = mid_rd_ff;
      q_item.up_old    = up_rd_ff;
      q_item.right     = right_rd_ff;
      q_item.prev_mid  = hist_mid_ff;
      q_item.prev_pix  = hist_pix_ff;
      q_item.prev2_pix = hist_pix2_ff;
      q_item.has_l1    = s1_has_l1_ff;
      q_item.has_l2    = s1_has_l2_ff;
      q_item.rowend    = s1_rowend_ff;
      q_item.has_up    = s1_has_up_ff;
      q_item.emit      = s1_emit_ff;
      q_item.last      = s1_last_ff;
   end

   a_accept_holds: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted pixel lost before the work queue");

endmodule
`default_nettype wire

### sv/psib_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psib_back: stencil sequencer
// Takes one neighbourhood word at a time and emits its zero to three
// blurred pixels, one per cycle unless res_full, via a single stencil unit.
// ----------------------------------------------------------------------------
module psib_back
   import psib_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            head_valid,
   input  wire psib_item_type   head,
   output      logic            q_pop,
   input  wire logic            res_full,
   output      logic            res_push,
   output      psib_result_type res_word
);

   localparam int RES_UPPER = 0;
   localparam int RES_LOWER = 1;
   localparam int RES_END   = 2;

   logic [2:0] done_ff, done_in;
   logic [2:0] mask, pend, sel, rest;
   logic [PIX_W-1:0] op_c, op_l, op_r, op_u, op_d;
   logic             op_hl, op_hr, op_hu, op_hd;

   // weighted plus stencil with rounding divide by eight
   function automatic logic [PIX_W-1:0] stencil(
      input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] l,
      input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] u,
      input logic [PIX_W-1:0] d, input logic hl, input logic hr,
      input logic hu, input logic hd);
      logic [PIX_W:0] h, v;
      logic [11:0]    c4, s, t;
      h  = (hl ? {1'b0, l} : '0) + (hr ? {1'b0, r} : '0);
      v  = (hu ? {1'b0, u} : '0) + (hd ? {1'b0, d} : '0);
      c4 = {2'b00, c, 2'b00};
      if (hl && hr && hu && hd) begin
         s = c4 + 12'(h) + 12'(v);
      end else if ((hl && hr) || (hu && hd)) begin
         s = c4 + 12'(c) + 12'(h) + 12'(v);
      end else begin
         s = c4 + {2'b00, h, 1'b0} + {2'b00, v, 1'b0};
      end
      t = s + 12'd4;
      return t[10:3];
   endfunction

   // pick the oldest result still owed by the head word
   always_comb begin
      mask[RES_UPPER] = head.emit;
      mask[RES_LOWER] = head.emit && head.last && head.has_l1;
      mask[RES_END]   = head.emit && head.last && head.rowend;
      pend = mask & ~done_ff;
      sel  = pend & (~pend + 3'd1);
      rest = pend & ~sel;
   end

   // route operands of the selected result
   always_comb begin
      if (sel[RES_UPPER]) begin
         op_c = head.mid_old;  op_l = head.prev_mid;  op_r = head.right;
         op_u = head.up_old;   op_d = head.pix;
         op_hl = head.has_l1;  op_hr = !head.rowend;
         op_hu = head.has_up;  op_hd = 1'b1;
      end else if (sel[RES_LOWER]) begin
         op_c = head.prev_pix; op_l = head.prev2_pix; op_r = head.pix;
         op_u = head.prev_mid; op_d = '0;
         op_hl = head.has_l2;  op_hr = 1'b1;
         op_hu = 1'b1;         op_hd = 1'b0;
      end else begin
         op_c = head.pix;      op_l = head.prev_pix;  op_r = '0;
         op_u = head.mid_old;  op_d = '0;
         op_hl = head.has_l1;  op_hr = 1'b0;
         op_hu = 1'b1;         op_hd = 1'b0;
      end
      res_word.pixel_out = stencil(op_c, op_l, op_r, op_u, op_d,
                                   op_hl, op_hr, op_hu, op_hd);
      res_word.frame_end = sel[RES_END];
   end

   // emit, then drop the head word once its last result is out
   always_comb begin
      res_push = head_valid && (pend != '0) && !res_full;
      q_pop    = head_valid && ((pend == '0) || (res_push && (rest == '0)));
      done_in  = done_ff;
      if (q_pop) begin
         done_in = '0;
      end else if (res_push) begin
         done_in = done_ff | sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0;
      end else begin
         done_ff <= done_in;
      end
   end

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> head_valid)
      else $error("work queue popped while empty");

   a_pop_clears: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (done_ff == '0))
      else $error("result progress kept across words");

   a_partial_kept: assert property (@(posedge clock) disable iff (reset)
      (res_push && !q_pop) |=> (done_ff != '0) && head_valid)
      else $error("partly emitted word lost its progress");

endmodule
`default_nettype wire

### sv/plus_stencil_image_blur.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plus_stencil_image_blur: streaming five-point blur of a grey frame
// Top level: intake front end, work queue, stencil back end, result queue.
// ----------------------------------------------------------------------------
// Pixels enter in raster order at one per cycle while full is low, and each
// blurred pixel leaves once its right and lower neighbours are in; results
// keep raster order except on the last row, where each pixel releases the
// pixel above it, then the last-row pixel to its left, and at the row end the
// frame's last pixel, which carries frame_end. While the queues have room the
// block sustains one pixel per cycle on all rows but the last, and on the last
// row its single stencil unit emits one result per cycle; that row owes one
// result for its first pixel, two for each pixel after it and three at its
// end. Results pass the capture registers, the work queue and the result
// queue, delayed when they back up. The line stores are two MAX_WIDTH by 8-bit
// memories in the front end, read on intake; they need no clearing pass after
// reset, and the frame size registers are to be written between frames.
module plus_stencil_image_blur
   import psib_pkg::*;
#(
   parameter int MAX_WIDTH   = 1024,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output      logic                  full,
   input  wire logic [PIX_W-1:0]      req_pixel_in,
   output      logic                  empty,
   input  wire logic                  pop,
   output      logic [PIX_W-1:0]      rsp_pixel_out,
   output      logic                  rsp_frame_end,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int ITEM_W = $bits(psib_item_type);
   localparam int RES_W  = $bits(psib_result_type);

   logic            q_push, q_full, q_pop, q_empty;
   psib_item_type   q_in, q_head;
   logic            res_push, res_full;
   psib_result_type res_in, res_head;

   psib_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .pixel_in  (req_pixel_in),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_in)
   );

   // decouple intake from the stencil back end
   psib_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_head),
      .empty     (q_empty)
   );

   psib_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!q_empty),
      .head       (q_head),
      .q_pop      (q_pop),
      .res_full   (res_full),
      .res_push   (res_push),
      .res_word   (res_in)
   );

   // hold finished words for the consumer
   psib_fifo #(
      .WIDTH (RES_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_in),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (res_head),
      .empty     (empty)
   );

   assign rsp_pixel_out = res_head.pixel_out;
   assign rsp_frame_end = res_head.frame_end;

endmodule
`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the plus-stencil image blur
// Streams grey frames of many sizes through the queue-style ports and checks
// every blurred word against a local five-point stencil predictor. Sizes
// change only between frames: a directed table first, then small random
// frames, then a frame during which the receiver holds off so the block fills.
// ----------------------------------------------------------------------------
module testbench
   import psib_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH   = 1024;
   localparam int DIR_ROWS     = 17;
   localparam int RANDOM_ITEMS = 160;
   localparam int SETTLE_WAIT  = 12;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 50000;
   localparam int MAX_REPORTS  = 40;

   // one row of the directed table
   typedef struct packed {
      bit                    new_frame;
      logic [CSR_DATA_W-1:0] width_wr;
      logic [CSR_DATA_W-1:0] height_wr;
      logic [PIX_W-1:0]      pix;
      bit                    typed;
      logic [PIX_W-1:0]      typed_out;
   } blur_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_frame_end;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic                  hold_off = 1'b0;
   bit                    squeeze_go = 1'b0;
   int                    cycle_count = 0;
   int                    mismatch_count = 0;
   logic                  quiet;

   // predictor state: line stores, input position, frame size
   logic [PIX_W-1:0]      upper_ln [LINE_DEPTH];
   logic [PIX_W-1:0]      middle_ln [LINE_DEPTH];
   int                    in_col;
   int                    in_row;
   logic [FW_W-1:0]       width_q;
   logic [FH_W-1:0]       height_q;
   psib_result_type       blur_due [$];

   plus_stencil_image_blur dut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_pixel_in  (req_pixel_in),
      .empty         (empty),
      .pop           (pop),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_frame_end (rsp_frame_end),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // long stretch with no idling on either side
   assign quiet = (cycle_count >= 200) && (cycle_count < 500);

   function automatic int eff_width(input logic [FW_W-1:0] w);
      return (w < 2) ? 2 : ((w > LINE_DEPTH) ? LINE_DEPTH : int'(w));
   endfunction

   function automatic int eff_height(input logic [FH_W-1:0] h);
      return (h < 2) ? 2 : int'(h);
   endfunction

   // weighted five-point sum, rounded divide by 8
   function automatic logic [PIX_W-1:0] plus_blur(input int ctr, input int lft,
         input int rgt, input int up, input int dn, input bit hl, input bit hr,
         input bit hu, input bit hd);
      int hsum;
      int vsum;
      int s;
      hsum = (hl ? lft : 0) + (hr ? rgt : 0);
      vsum = (hu ? up : 0) + (hd ? dn : 0);
      if (hl && hr && hu && hd) begin
         s = 4 * ctr + hsum + vsum;
      end else if ((hl && hr) || (hu && hd)) begin
         s = 5 * ctr + hsum + vsum;
      end else begin
         s = 4 * ctr + 2 * hsum + 2 * vsum;
      end
      return PIX_W'((s + 4) >> 3);
   endfunction

   task automatic add_due(input logic [PIX_W-1:0] v, input logic fe, input bit typed,
         input logic [PIX_W-1:0] typed_out);
      psib_result_type r;
      r.pixel_out = typed ? typed_out : v;
      r.frame_end = fe;
      blur_due.push_back(r);
   endtask

   // advance the predictor by one accepted pixel and queue what it releases
   task automatic track_pixel(input logic [PIX_W-1:0] pix, input bit typed,
         input logic [PIX_W-1:0] typed_out);
      int w;
      int h;
      int c;
      bit last_row;
      bit row_end;
      logic [PIX_W-1:0] up_old;
      logic [PIX_W-1:0] mid_old;
      logic [PIX_W-1:0] lft;
      logic [PIX_W-1:0] rgt;
      w = eff_width(width_q);
      h = eff_height(height_q);
      c = in_col;
      last_row = (in_row + 1 >= h);
      row_end = (c + 1 >= w);
      up_old = upper_ln[c];
      mid_old = middle_ln[c];
      upper_ln[c] = mid_old;
      middle_ln[c] = pix;
      if (in_row >= 1) begin
         // pixel one row above the input
         lft = (c >= 1) ? upper_ln[c-1] : 8'd0;
         rgt = (c + 1 < LINE_DEPTH) ? middle_ln[c+1] : 8'd0;
         add_due(plus_blur(int'(mid_old), int'(lft), int'(rgt), int'(up_old), int'(pix),
                           c >= 1, !row_end, in_row - 1 != 0, 1'b1),
                 1'b0, typed, typed_out);
         if (last_row) begin
            // last-row pixel to the left of the input
            if (c >= 1) begin
               add_due(plus_blur(int'(middle_ln[c-1]),
                                 (c >= 2) ? int'(middle_ln[c-2]) : 0, int'(pix),
                                 int'(upper_ln[c-1]), 0, c >= 2, 1'b1, 1'b1, 1'b0),
                       1'b0, typed, typed_out);
            end
            // last pixel of the frame
            if (row_end) begin
               add_due(plus_blur(int'(pix), (c >= 1) ? int'(middle_ln[c-1]) : 0, 0,
                                 int'(mid_old), 0, c >= 1, 1'b0, 1'b1, 1'b0),
                       1'b1, typed, typed_out);
            end
         end
      end
      if (row_end) begin
         in_col = 0;
         in_row = last_row ? 0 : in_row + 1;
      end else begin
         in_col = c + 1;
      end
   endtask

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch @ %0t: %s", $realtime, what);
      end
   endtask

   // offer one word, idling at random first; returns at the accepting edge
   task automatic send_word(input logic [PIX_W-1:0] pix, input bit typed,
         input logic [PIX_W-1:0] typed_out);
      while (!quiet && $urandom_range(0, 99) < 12) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_pixel_in <= pix;
      do @(posedge clock); while (full);
      track_pixel(pix, typed, typed_out);
   endtask

   // hold the input until every due word is out and the pipe is quiet
   task automatic settle();
      push <= 1'b0;
      while (blur_due.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // write both size registers while the block is idle
   task automatic set_frame(input logic [CSR_DATA_W-1:0] wdata,
         input logic [CSR_DATA_W-1:0] hdata);
      settle();
      csr_we <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_data <= wdata;
      @(posedge clock);
      width_q = wdata[FW_W-1:0];
      csr_index <= CSR_FRAME_HEIGHT;
      csr_data <= hdata;
      @(posedge clock);
      height_q = hdata[FH_W-1:0];
      csr_we <= 1'b0;
   endtask

   // one complete frame of random content
   task automatic send_frame(input logic [CSR_DATA_W-1:0] wdata,
         input logic [CSR_DATA_W-1:0] hdata, input bit squeeze, output int count);
      logic [PIX_W-1:0] pix;
      set_frame(wdata, hdata);
      count = eff_width(width_q) * eff_height(height_q);
      if (squeeze) begin
         squeeze_go = 1'b1;
      end
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            pix = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         end else begin
            pix = PIX_W'($urandom_range(0, 255));
         end
         send_word(pix, 1'b0, 8'd0);
      end
   endtask

   // receiver: idle at random, stall hard while held off
   always @(posedge clock) begin
      pop <= !reset && !hold_off && (quiet || $urandom_range(0, 99) >= 12);
   end

   // long receiver hold-off once results flow, so the block fills and pushes back
   initial begin
      wait (squeeze_go && in_row >= 1);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // check each accepted word against the oldest due one
   always @(posedge clock) begin
      psib_result_type want;
      if (!reset && pop && !empty) begin
         if (blur_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected word pixel_out=%0d frame_end=%0b",
                                    rsp_pixel_out, rsp_frame_end));
         end else begin
            want = blur_due.pop_front();
            if (rsp_pixel_out !== want.pixel_out) begin
               flag_mismatch($sformatf("pixel_out %0d, want %0d",
                                       rsp_pixel_out, want.pixel_out));
            end
            if (rsp_frame_end !== want.frame_end) begin
               flag_mismatch($sformatf("frame_end %0b, want %0b",
                                       rsp_frame_end, want.frame_end));
            end
         end
      end
   end

   // run limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[plus_stencil_image_blur] ERROR");
      $finish;
   end

   initial begin
      blur_row_type directed_rows [DIR_ROWS];
      int random_items;
      int count;
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] hdata;
      int pick;

      // flat white 2x2 (width below range, height zero), flat black 2x2 with
      // high width bits set, then a 3x3 frame with interior, edges, corners
      directed_rows = '{
         '{1'b1, 16'd1,     16'd0, 8'd255, 1'b1, 8'd255},
         '{1'b0, 16'd0,     16'd0, 8'd255, 1'b1, 8'd255},
         '{1'b0, 16'd0,     16'd0, 8'd255, 1'b1, 8'd255},
         '{1'b0, 16'd0,     16'd0, 8'd255, 1'b1, 8'd255},
         '{1'b1, 16'hF802,  16'd2, 8'd0,   1'b1, 8'd0},
         '{1'b0, 16'd0,     16'd0, 8'd0,   1'b1, 8'd0},
         '{1'b0, 16'd0,     16'd0, 8'd0,   1'b1, 8'd0},
         '{1'b0, 16'd0,     16'd0, 8'd0,   1'b1, 8'd0},
         '{1'b1, 16'd3,     16'd3, 8'd0,   1'b0, 8'd0},
         '{1'b0, 16'd0,     16'd0, 8'd255, 1'b0, 8'd0},
         '{1'b0, 16'd0,     16'd0, 8'd0,   1'b0, 8'd0},
         '{1'b0, 16'd0,     16'd0, 8'd255, 1'b0, 8'd0},
         '{1'b0, 16'd0,     16'd0, 8'd128, 1'b0, 8'd0},
         '{1'b0, 16'd0,     16'd0, 8'd255, 1'b0, 8'd0},
         '{1'b0, 16'd0,     16'd0, 8'd0,   1'b0, 8'd0},
         '{1'b0, 16'd0,     16'd0, 8'd255, 1'b0, 8'd0},
         '{1'b0, 16'd0,     16'd0, 8'd1,   1'b0, 8'd0}
      };

      // predictor reset state
      for (int i = 0; i < LINE_DEPTH; i++) begin
         upper_ln[i] = '0;
         middle_ln[i] = '0;
      end
      in_col = 0;
      in_row = 0;
      width_q = FRAME_WIDTH_RESET;
      height_q = FRAME_HEIGHT_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].new_frame) begin
            set_frame(directed_rows[i].width_wr, directed_rows[i].height_wr);
         end
         send_word(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].typed_out);
      end

      // small random frames, with out-of-range sizes and junk high width bits
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         wdata[CSR_DATA_W-1:FW_W] = (CSR_DATA_W - FW_W)'($urandom);
         wdata[FW_W-1:0] = (pick == 0) ? 11'd0 :
                           (pick == 1) ? 11'd1 : FW_W'($urandom_range(2, 12));
         pick = $urandom_range(0, 9);
         hdata = (pick == 0) ? 16'd0 :
                 (pick == 1) ? 16'd1 : CSR_DATA_W'($urandom_range(2, 6));
         send_frame(wdata, hdata, 1'b0, count);
         random_items += count;
      end

      // frame sent while the receiver holds off
      send_frame(16'd8, 16'd4, 1'b1, count);

      settle();
      if (mismatch_count == 0 && blur_due.size() == 0) begin
         $display("[plus_stencil_image_blur] OK");
      end else begin
         $display("[plus_stencil_image_blur] ERROR");
      end
      $finish;
   end

endmodule
